FILE: design/vfc_pkg.sv
// Shared types, widths and plane tables for the view frustum culler.
// No dependencies; imported by vfc_plane and view_frustum_cull.
package vfc_pkg;

   localparam int VALUE_WIDTH = 32;               // Q16.16 coordinates and matrix elements
   localparam int FRAC_BITS   = 16;
   localparam int NUM_PLANES  = 6;
   localparam int NUM_ROWS    = 4;
   localparam int NUM_AXES    = 3;
   localparam int ROW_W       = 2;
   localparam int NUM_VALUES  = 7;                // first_x .. upper_z

   localparam int COEF_W = VALUE_WIDTH + 1;       // column four plus or minus another column
   localparam int PROD_W = COEF_W + VALUE_WIDTH;  // exact coefficient times coordinate
   localparam int SUM_W  = PROD_W + 2;            // three products plus the w term

   localparam int REQ_FIELD_W = ROW_W + NUM_VALUES * VALUE_WIDTH;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 8;

   localparam int PLANE_W = 3;
   localparam logic [PLANE_W-1:0] PLANE_NONE = 3'd6;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [COEF_W-1:0]      coef_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_POINT = 2'd1,
      OP_BOX   = 2'd2
   } opcode_type;

   // Per plane: matrix column combined with column four, and whether it is subtracted.
   // Order: near, far, left, right, top, bottom.
   localparam logic [1:0] PLANE_COL [NUM_PLANES] = '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
   localparam logic       PLANE_NEG [NUM_PLANES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   // Load enables of the four datapath stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } vfc_adv_type;

endpackage

FILE: design/vfc_plane.sv
// One plane lane: corner select, three multiplies, adder tree and sign test.
// Depends on vfc_pkg.
module vfc_plane
   import vfc_pkg::*;
(
   input  logic        clock,
   input  vfc_adv_type adv_i,
   input  coef_type    coef_i [NUM_ROWS],
   input  value_type   lo_i [NUM_AXES],
   input  value_type   hi_i [NUM_AXES],
   output logic        pos_o
);

   logic [NUM_AXES-1:0] pick_hi;
   value_type sel_in [NUM_AXES];
   value_type sel_ff [NUM_AXES];
   coef_type  coef_ff [NUM_ROWS];
   prod_type  prod_in [NUM_AXES];
   prod_type  prod_ff [NUM_AXES];
   coef_type  w_ff;
   sum_type   sum_a_ff;
   sum_type   sum_b_ff;
   sum_type   total;
   logic      pos_ff;

   // Best corner per axis: larger coordinate for a non-negative coefficient, smaller otherwise.
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         pick_hi[a] = (lo_i[a] < hi_i[a]) ^ coef_i[a][COEF_W-1];
         sel_in[a]  = pick_hi[a] ? hi_i[a] : lo_i[a];
         prod_in[a] = PROD_W'(coef_ff[a]) * PROD_W'(sel_ff[a]);
      end
      total = sum_a_ff + sum_b_ff;
   end

   always_ff @(posedge clock) begin
      if (adv_i.s1) begin
         sel_ff  <= sel_in;
         coef_ff <= coef_i;
      end
      if (adv_i.s2) begin
         prod_ff <= prod_in;
         w_ff    <= coef_ff[NUM_ROWS-1];
      end
      if (adv_i.s3) begin
         sum_a_ff <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]);
         sum_b_ff <= SUM_W'(prod_ff[2]) + (SUM_W'(w_ff) <<< FRAC_BITS);
      end
      if (adv_i.s4) begin
         pos_ff <= !total[SUM_W-1] && (total != '0);
      end
   end

   assign pos_o = pos_ff;

endmodule

FILE: design/view_frustum_cull.sv
// View frustum culler top level: handshakes, plane coefficient store, result encode.
// Depends on vfc_pkg and vfc_plane.
//
//  channel  dir  width  transfer carries
//  req      in   232    tdata: row_index, first_x/y/z, row_w, upper_x/y/z; tuser: opcode
//  rsp      out  8      tdata: visible, rejecting_plane (one per point or box test)
//
// One item per cycle sustained while rsp_tready stays high; a test's result is registered
// through select, multiply, add, add-and-sign and encode. Each of the six plane lanes
// holds three multipliers, so the multiply stage sets the pace at one test per cycle.
// Loads write the coefficient store at transfer and give no result;
// a test taken right after a load already sees the new row.
// Reset clears all valid bits and the coefficient store (a zero matrix).
// Each stage holds until the one after it frees up, so bubbles are squeezed out
// and nothing is dropped or repeated under rsp_tready stalls.
module view_frustum_cull
   import vfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] row_index, [33:2] first_x, [65:34] first_y, [97:66] first_z,
   // [129:98] row_w, [161:130] upper_x, [193:162] upper_y, [225:194] upper_z, rest zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] visible, [3:1] rejecting_plane, [7:4] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Plane coefficients: column four plus or minus column one, two or three, per row.
   // This is the only form of the matrix that the tests ever read.
   coef_type coef_ff [NUM_PLANES][NUM_ROWS];

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic out_valid_ff;
   logic visible_ff;
   logic [PLANE_W-1:0] plane_ff;

   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic req_xfer, is_test, is_box, is_load;
   logic [ROW_W-1:0] row_index;
   value_type fld [NUM_VALUES];
   value_type lo [NUM_AXES];
   value_type hi [NUM_AXES];
   logic [NUM_PLANES-1:0] pos;
   logic [PLANE_W-1:0] plane_in;
   vfc_adv_type adv;

   // Ready chain from the output register back to the input.
   assign rdy5 = !out_valid_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_xfer = req_tvalid && req_tready;

   assign adv = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

   always_comb begin
      is_test = 1'b0;
      is_box  = 1'b0;
      is_load = 1'b0;
      case (opcode_type'(req_tuser))
         OP_LOAD:  is_load = 1'b1;
         OP_POINT: is_test = 1'b1;
         OP_BOX: begin
            is_test = 1'b1;
            is_box  = 1'b1;
         end
         default: ;  // unused opcode: dropped
      endcase
   end

   // Field unpack; a point is a box with both corners equal.
   assign row_index = req_tdata[ROW_W-1:0];
   always_comb begin
      for (int i = 0; i < NUM_VALUES; i++) begin
         fld[i] = req_tdata[ROW_W + i*VALUE_WIDTH +: VALUE_WIDTH];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         lo[a] = fld[a];
         hi[a] = is_box ? fld[NUM_AXES + 1 + a] : fld[a];
      end
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      vfc_plane u_plane (
         .clock  (clock),
         .adv_i  (adv),
         .coef_i (coef_ff[p]),
         .lo_i   (lo),
         .hi_i   (hi),
         .pos_o  (pos[p])
      );
   end

   // First plane with no positive corner rejects.
   always_comb begin
      plane_in = PLANE_NONE;
      for (int p = NUM_PLANES - 1; p >= 0; p--) begin
         if (!pos[p]) begin
            plane_in = PLANE_W'(p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
               coef_ff[p][r] <= '0;
            end
         end
      end else begin
         if (rdy1) v1_ff <= req_xfer && is_test;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) begin
            out_valid_ff <= v4_ff;
            visible_ff   <= (plane_in == PLANE_NONE);
            plane_ff     <= plane_in;
         end
         if (req_xfer && is_load) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
               if (PLANE_NEG[p]) begin
                  coef_ff[p][row_index] <= COEF_W'(fld[NUM_AXES])
                                          - COEF_W'(fld[PLANE_COL[p]]);
               end else begin
                  coef_ff[p][row_index] <= COEF_W'(fld[NUM_AXES])
                                          + COEF_W'(fld[PLANE_COL[p]]);
               end
            end
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - PLANE_W - 1){1'b0}}, plane_ff, visible_ff};

   // A load or dropped opcode never puts an item into the pipe.
   a_load_no_item: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !is_test) |=> !v1_ff)
      else $error("non-test transfer entered the pipeline");

   // Every test transfer occupies the first stage on the next cycle.
   a_test_enters: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_test) |=> v1_ff)
      else $error("test transfer lost at pipeline entry");

   // Input only stalls when every stage is full and the output is blocked.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled with a bubble in the pipeline");

   // Visible exactly when no plane rejects.
   a_visible_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (visible_ff == (plane_ff == PLANE_NONE)))
      else $error("visible flag disagrees with rejecting plane");

endmodule

FILE: verif/view_frustum_cull_test.sv
// Self-checking testbench for view_frustum_cull: stream driver, result sink and scoreboard.
// Depends on vfc_pkg and the view_frustum_cull RTL; the culling predictor is its own.
module view_frustum_cull_test;
   import vfc_pkg::*;

   // Q16.16 one, value extremes and the opcode the block ignores
   localparam int ONE = 1 << FRAC_BITS;
   localparam value_type VALUE_MIN = value_type'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
   localparam value_type VALUE_MAX = ~VALUE_MIN;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1900;
   localparam int PAUSE_EVERY  = 600;    // sender drains the block this often
   localparam int DRAIN_CYCLES = 20;     // idle clocks after the last verdict returns
   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic                 visible;
      logic [PLANE_W-1:0]   plane;
   } verdict_type;

   // Scoreboard: a private copy of the matrix store, the culling predictor and the
   // queue of verdicts still owed by the block.
   class cull_scoreboard;
      value_type   matrix [NUM_ROWS*4];
      int          plane_col [NUM_PLANES];
      bit          plane_sub [NUM_PLANES];
      verdict_type verdicts [$];
      int          failures;
      int          results_seen;
      int          loads, points, boxes, ignored, visible_count;
      int          rejects [NUM_PLANES+1];

      function new();
         foreach (matrix[i]) matrix[i] = '0;
         // near, far, left, right, top, bottom: column paired with column four
         plane_col = '{2, 2, 0, 0, 1, 1};
         plane_sub = '{0, 1, 0, 1, 1, 0};
      endfunction

      // Sign of the plane dot (x, y, z, 1.0), formed exactly at the product scale.
      function bit plane_positive(int p, value_type px, value_type py, value_type pz);
         sum_type acc, c4, ck, coef, coord;
         acc = '0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            c4 = sum_type'(matrix[r*4 + 3]);
            ck = sum_type'(matrix[r*4 + plane_col[p]]);
            coef = plane_sub[p] ? c4 - ck : c4 + ck;
            case (r)
               0: coord = sum_type'(px);
               1: coord = sum_type'(py);
               2: coord = sum_type'(pz);
               default: coord = sum_type'(ONE);
            endcase
            acc = acc + coef * coord;
         end
         return !acc[SUM_W-1] && (acc != '0);
      endfunction

      function void note_request(logic [1:0] op, logic [REQ_TDATA_W-1:0] data);
         value_type   v [NUM_VALUES];
         int          row;
         int          reject;
         bit          any;
         verdict_type vd;
         row = data[ROW_W-1:0];
         for (int k = 0; k < NUM_VALUES; k++)
            v[k] = data[ROW_W + k*VALUE_WIDTH +: VALUE_WIDTH];
         reject = NUM_PLANES;
         case (op)
            OP_LOAD: begin
               for (int c = 0; c < 4; c++) matrix[row*4 + c] = v[c];
               loads++;
               return;
            end
            OP_POINT: begin
               points++;
               for (int p = 0; p < NUM_PLANES && reject == NUM_PLANES; p++)
                  if (!plane_positive(p, v[0], v[1], v[2])) reject = p;
            end
            OP_BOX: begin
               // corners mix min (v[0..2]) and max (v[4..6]); order of the two is free
               boxes++;
               for (int p = 0; p < NUM_PLANES && reject == NUM_PLANES; p++) begin
                  any = 1'b0;
                  for (int c = 0; c < 8 && !any; c++)
                     any = plane_positive(p, v[(c & 1) ? 4 : 0], v[(c & 2) ? 5 : 1],
                                          v[(c & 4) ? 6 : 2]);
                  if (!any) reject = p;
               end
            end
            default: begin
               ignored++;
               return;
            end
         endcase
         vd.visible = (reject == NUM_PLANES);
         vd.plane   = vd.visible ? PLANE_NONE : reject[PLANE_W-1:0];
         rejects[reject]++;
         if (vd.visible) visible_count++;
         verdicts.push_back(vd);
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= MAX_REPORTS) $display("%s", what);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data);
         verdict_type want;
         results_seen++;
         if (verdicts.size() == 0) begin
            flag($sformatf("result %0d arrived with none expected: visible %0b plane %0d",
                           results_seen, data[0], data[3:1]));
            return;
         end
         want = verdicts.pop_front();
         if (data[0] !== want.visible || data[3:1] !== want.plane)
            flag($sformatf("result %0d: expected visible %0b plane %0d, got visible %0b plane %0d",
                           results_seen, want.visible, want.plane, data[0], data[3:1]));
      endfunction

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;    // row_index, first_x/y/z, row_w, upper_x/y/z
   logic [1:0]             req_tuser = '0;    // opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // visible, rejecting_plane

   cull_scoreboard sb;
   int unsigned    cycle_count = 0;
   int             items_sent  = 0;           // loads and tests, not ignored opcodes
   bit             req_idle_on = 1'b1;        // off: back-to-back transfers
   bit             rsp_idle_on = 1'b1;        // off: rsp_tready held high

   view_frustum_cull dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL view_frustum_cull");
         $finish;
      end
   end

   // Every result transfer is checked against the oldest outstanding verdict.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Result sink: per result, a random stall unless idling is off.
   initial begin : result_sink
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // One transfer on req: optional gap, then hold until req_tready is seen at an edge.
   // The item is handed to the scoreboard at the edge that accepted it.
   task automatic send_item(logic [1:0] op, logic [1:0] row, value_type fx, value_type fy,
                            value_type fz, value_type w, value_type ux, value_type uy,
                            value_type uz);
      logic [REQ_TDATA_W-1:0] data;
      int                     gap;
      data = '0;
      data[ROW_W-1:0] = row;
      data[ROW_W + 0*VALUE_WIDTH +: VALUE_WIDTH] = fx;
      data[ROW_W + 1*VALUE_WIDTH +: VALUE_WIDTH] = fy;
      data[ROW_W + 2*VALUE_WIDTH +: VALUE_WIDTH] = fz;
      data[ROW_W + 3*VALUE_WIDTH +: VALUE_WIDTH] = w;
      data[ROW_W + 4*VALUE_WIDTH +: VALUE_WIDTH] = ux;
      data[ROW_W + 5*VALUE_WIDTH +: VALUE_WIDTH] = uy;
      data[ROW_W + 6*VALUE_WIDTH +: VALUE_WIDTH] = uz;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, data);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Mostly random values, with the extremes and +/-1.0 mixed in.
   function automatic value_type wild_value();
      case ($urandom_range(0, 15))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return value_type'(ONE);
         4: return -value_type'(ONE);
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic value_type rand_fixed(int span);
      return value_type'(int'($urandom_range(0, 2*span)) - span);
   endfunction

   // Load and test wrappers; fields the block ignores carry random bits.
   task automatic load_row(int row, value_type e0, value_type e1, value_type e2, value_type e3);
      send_item(OP_LOAD, row[1:0], e0, e1, e2, e3, wild_value(), wild_value(), wild_value());
   endtask

   task automatic test_point(value_type x, value_type y, value_type z);
      send_item(OP_POINT, 2'($urandom_range(0, 3)), x, y, z, wild_value(),
                wild_value(), wild_value(), wild_value());
   endtask

   task automatic test_box(value_type lx, value_type ly, value_type lz,
                           value_type hx, value_type hy, value_type hz);
      send_item(OP_BOX, 2'($urandom_range(0, 3)), lx, ly, lz, wild_value(), hx, hy, hz);
   endtask

   // Plausible projection row: diagonal scale 0.5..2.0, small shear, translation
   // in row three, w scale 0.75..1.5. Keeps test outcomes spread over all planes.
   task automatic load_frustum_row(int row);
      value_type e [4];
      for (int c = 0; c < 4; c++) begin
         if (row == c && row < 3)      e[c] = value_type'($urandom_range(ONE/2, 2*ONE));
         else if (row == 3 && c == 3)  e[c] = value_type'($urandom_range(3*ONE/4, 3*ONE/2));
         else if (row == 3)            e[c] = rand_fixed(ONE/4);
         else                          e[c] = $urandom_range(0, 1) ? rand_fixed(ONE/8) : '0;
      end
      load_row(row, e[0], e[1], e[2], e[3]);
   endtask

   // Whole plausible matrix, rows written in shuffled order.
   task automatic load_frustum();
      int order [4];
      int j, tmp;
      order = '{0, 1, 2, 3};
      for (int i = 3; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) load_frustum_row(order[i]);
   endtask

   // Sender holds off until the block has returned every verdict.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int        pick, start, next_pause;
      value_type lo [3], hi [3], t;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // zero matrix out of reset: every test culled at the near plane
      test_point('0, '0, '0);
      test_box(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MAX);
      // ignored opcode must leave the store alone
      send_item(OP_UNUSED, 2'd3, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX,
                VALUE_MAX, VALUE_MAX, VALUE_MAX);
      test_point(value_type'(ONE/2), '0, '0);
      // identity: frustum is the open cube -1 < x, y, z < 1
      load_row(0, value_type'(ONE), '0, '0, '0);
      load_row(1, '0, value_type'(ONE), '0, '0);
      load_row(2, '0, '0, value_type'(ONE), '0);
      load_row(3, '0, '0, '0, value_type'(ONE));
      test_point('0, '0, '0);
      // points exactly on each face: dot product zero, so culled in plane order
      test_point('0, '0, -value_type'(ONE));
      test_point('0, '0, value_type'(ONE));
      test_point(-value_type'(ONE), '0, '0);
      test_point(value_type'(ONE), '0, '0);
      test_point('0, value_type'(ONE), '0);
      test_point('0, -value_type'(ONE), '0);
      // swapped box corners, a box wholly past the right face, the full range box
      test_box(value_type'(ONE/2), value_type'(ONE/2), value_type'(ONE/2),
               -value_type'(ONE/2), -value_type'(ONE/2), -value_type'(ONE/2));
      test_box(value_type'(ONE), -value_type'(ONE/2), '0,
               value_type'(3*ONE), value_type'(ONE/2), value_type'(ONE/4));
      test_box(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MAX);
      test_point(VALUE_MAX, VALUE_MAX, VALUE_MAX);
      test_point(VALUE_MIN, VALUE_MIN, VALUE_MIN);
      // extreme elements: plane coefficients need the extra bit
      load_row(3, VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX);
      load_row(0, VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MAX);
      test_point(VALUE_MAX, VALUE_MIN, VALUE_MAX);
      test_box(VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX);

      // --- random ---
      // Mostly plausible matrices with tests near the frustum; some wild matrices,
      // wild coordinates, partial reloads and ignored opcodes as noise.
      load_frustum();
      start = items_sent;
      next_pause = items_sent + PAUSE_EVERY;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) == 0) req_idle_on = !req_idle_on;
         if ($urandom_range(0, 99) == 0) rsp_idle_on = !rsp_idle_on;
         if (items_sent >= next_pause) begin
            wait_for_results();
            next_pause += PAUSE_EVERY;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            load_frustum();
         end else if (pick < 4) begin
            for (int r = 0; r < NUM_ROWS; r++)
               load_row(r, wild_value(), wild_value(), wild_value(), wild_value());
         end else if (pick < 6) begin
            load_frustum_row($urandom_range(0, 3));
         end else if (pick < 8) begin
            send_item(OP_UNUSED, 2'($urandom_range(0, 3)), wild_value(), wild_value(),
                      wild_value(), wild_value(), wild_value(), wild_value(), wild_value());
         end else if (pick < 50) begin
            test_point(rand_fixed(ONE), rand_fixed(ONE), rand_fixed(ONE));
         end else if (pick < 92) begin
            for (int a = 0; a < 3; a++) begin
               lo[a] = rand_fixed(ONE);
               hi[a] = lo[a] + value_type'($urandom_range(0, ONE/2));
               if ($urandom_range(0, 3) == 0) begin
                  t = lo[a];
                  lo[a] = hi[a];
                  hi[a] = t;
               end
            end
            test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
         end else if (pick < 96) begin
            test_point(wild_value(), wild_value(), wild_value());
         end else begin
            test_box(wild_value(), wild_value(), wild_value(),
                     wild_value(), wild_value(), wild_value());
         end
      end

      // --- drain and report ---
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d row loads, %0d point and %0d box tests (%0d visible), %0d ignored",
               sb.loads, sb.points, sb.boxes, sb.visible_count, sb.ignored);
      $display("culled near/far/left/right/top/bottom %0d/%0d/%0d/%0d/%0d/%0d; %0d failures",
               sb.rejects[0], sb.rejects[1], sb.rejects[2], sb.rejects[3],
               sb.rejects[4], sb.rejects[5], sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS view_frustum_cull");
      end else begin
         $display("FAIL view_frustum_cull");
      end
      $finish;
   end

endmodule
